### rtl/core/ordered_list_engine_defines.svh
// ---------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shared check macros for the ordered list engine; clocked on clk, held off
// while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_DEFINES_SVH
`define ORDERED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication check
`define OLE_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication check
`define OLE_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ole_pkg.sv
// ---------------------------------------------------------------------------
// Ordered list engine package
// Sizes, action and status codes, and the structs passed between modules.
// ---------------------------------------------------------------------------
package ole_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int DATA_W = 32;
	localparam int ACT_W  = 3;
	localparam int POS_W  = 5;
	localparam int ST_W   = 3;
	localparam int FIDX_W = 4;
	localparam int OCNT_W = 5;

	localparam logic [ACT_W-1:0] ACT_ADD_FRONT  = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ADD_BACK   = 3'd1;
	localparam logic [ACT_W-1:0] ACT_DROP_FRONT = 3'd2;
	localparam logic [ACT_W-1:0] ACT_DROP_BACK  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_INSERT     = 3'd4;
	localparam logic [ACT_W-1:0] ACT_SEARCH     = 3'd5;

	localparam logic [ST_W-1:0] ST_OK       = 3'd0;
	localparam logic [ST_W-1:0] ST_EMPTY    = 3'd1;
	localparam logic [ST_W-1:0] ST_BADPOS   = 3'd2;
	localparam logic [ST_W-1:0] ST_FULL     = 3'd3;
	localparam logic [ST_W-1:0] ST_NOTFOUND = 3'd4;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [DATA_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} ole_mem_req_t;

	typedef struct packed {
		logic [ST_W-1:0]  status;
		logic [IDX_W-1:0] found;
		logic [CNT_W-1:0] count;
	} ole_res_t;

endpackage

### rtl/core/ole_store.sv
// ---------------------------------------------------------------------------
// Ordered list engine entry store
// One write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module ole_store (
	input  logic                       clk,
	input  ole_pkg::ole_mem_req_t      req,
	output logic [ole_pkg::DATA_W-1:0] rdata
);

	logic [ole_pkg::DATA_W-1:0] mem_q [ole_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[req.waddr] <= req.wdata;
		end
		rdata <= mem_q[req.raddr];
	end

endmodule

### rtl/core/ole_seq.sv
// ---------------------------------------------------------------------------
// Ordered list engine sequencer
// Walks the store one entry per cycle through a shared address stepper, with
// a key comparator for search: shifts entries up for insert and push front,
// down for pop front, and scans for search.
// ---------------------------------------------------------------------------
module ole_seq (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [ole_pkg::ACT_W-1:0]         action,
	input  logic signed [ole_pkg::DATA_W-1:0] value,
	input  logic [ole_pkg::POS_W-1:0]         position,
	input  logic signed [ole_pkg::DATA_W-1:0] key,
	output logic                              idle,
	output logic                              res_valid,
	input  logic                              res_take,
	output ole_pkg::ole_res_t                 res,
	output ole_pkg::ole_mem_req_t             mem_req,
	input  logic [ole_pkg::DATA_W-1:0]        rdata
);

	typedef enum logic [2:0] {S_IDLE, S_WALK, S_DRAIN, S_PUT, S_FIN} state_t;
	typedef enum logic [1:0] {W_RIGHT, W_LEFT, W_SEARCH} walk_t;

	state_t                     st_q;
	walk_t                      mode_q;
	logic [ole_pkg::CNT_W-1:0]  count_q;
	logic [ole_pkg::DATA_W-1:0] val_q;
	logic [ole_pkg::DATA_W-1:0] key_q;
	logic [ole_pkg::IDX_W-1:0]  pos_q;
	logic [ole_pkg::IDX_W-1:0]  rd_q;
	logic [ole_pkg::IDX_W-1:0]  end_q;
	logic                       pend_q;
	logic [ole_pkg::IDX_W-1:0]  pend_a_q;
	logic [ole_pkg::ST_W-1:0]   status_q;
	logic [ole_pkg::IDX_W-1:0]  found_q;

	logic                      hit;
	logic                      bad_pos;
	logic                      full;
	logic [ole_pkg::CNT_W-1:0] add_pos;
	logic [ole_pkg::CNT_W-1:0] last_cnt;

	assign idle      = (st_q == S_IDLE);
	assign res_valid = (st_q == S_FIN);
	assign res       = '{status: status_q, found: found_q, count: count_q};

	always_comb begin
		hit      = pend_q && (rdata == key_q);
		full     = (count_q == ole_pkg::CNT_W'(ole_pkg::DEPTH));
		bad_pos  = (action == ole_pkg::ACT_INSERT) && (32'(position) > 32'(count_q));
		last_cnt = count_q - ole_pkg::CNT_W'(1);
		case (action)
			ole_pkg::ACT_ADD_FRONT: add_pos = '0;
			ole_pkg::ACT_ADD_BACK:  add_pos = count_q;
			default:                add_pos = ole_pkg::CNT_W'(position);
		endcase

		mem_req.we    = 1'b0;
		mem_req.waddr = pos_q;
		mem_req.wdata = val_q;
		mem_req.raddr = rd_q;
		if ((st_q == S_WALK || st_q == S_DRAIN) && pend_q && mode_q != W_SEARCH) begin
			mem_req.we    = 1'b1;
			mem_req.wdata = rdata;
			mem_req.waddr = (mode_q == W_RIGHT) ? pend_a_q + ole_pkg::IDX_W'(1)
			                                    : pend_a_q - ole_pkg::IDX_W'(1);
		end else if (st_q == S_PUT) begin
			mem_req.we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			mode_q   <= W_RIGHT;
			count_q  <= '0;
			pend_q   <= 1'b0;
			status_q <= ole_pkg::ST_OK;
			found_q  <= '0;
		end else begin
			case (st_q)
				S_IDLE: begin
					if (start) begin
						val_q    <= value;
						key_q    <= key;
						pend_q   <= 1'b0;
						found_q  <= '0;
						status_q <= ole_pkg::ST_OK;
						st_q     <= S_FIN;
						case (action)
							ole_pkg::ACT_ADD_FRONT, ole_pkg::ACT_ADD_BACK,
							ole_pkg::ACT_INSERT: begin
								pos_q <= ole_pkg::IDX_W'(add_pos);
								end_q <= ole_pkg::IDX_W'(add_pos);
								rd_q  <= ole_pkg::IDX_W'(last_cnt);
								if (bad_pos) begin
									status_q <= ole_pkg::ST_BADPOS;
								end else if (full) begin
									status_q <= ole_pkg::ST_FULL;
								end else if (add_pos == count_q) begin
									st_q <= S_PUT;
								end else begin
									mode_q <= W_RIGHT;
									st_q   <= S_WALK;
								end
							end
							ole_pkg::ACT_DROP_FRONT: begin
								rd_q  <= ole_pkg::IDX_W'(1);
								end_q <= ole_pkg::IDX_W'(last_cnt);
								if (count_q == '0) begin
									status_q <= ole_pkg::ST_EMPTY;
								end else if (count_q == ole_pkg::CNT_W'(1)) begin
									count_q <= last_cnt;
								end else begin
									mode_q <= W_LEFT;
									st_q   <= S_WALK;
								end
							end
							ole_pkg::ACT_DROP_BACK: begin
								if (count_q == '0) begin
									status_q <= ole_pkg::ST_EMPTY;
								end else begin
									count_q <= last_cnt;
								end
							end
							ole_pkg::ACT_SEARCH: begin
								status_q <= ole_pkg::ST_NOTFOUND;
								rd_q     <= '0;
								end_q    <= ole_pkg::IDX_W'(last_cnt);
								if (count_q != '0) begin
									mode_q <= W_SEARCH;
									st_q   <= S_WALK;
								end
							end
							default: begin
								st_q <= S_FIN;
							end
						endcase
					end
				end
				S_WALK: begin
					pend_q   <= 1'b1;
					pend_a_q <= rd_q;
					if (mode_q == W_SEARCH && hit) begin
						status_q <= ole_pkg::ST_OK;
						found_q  <= pend_a_q;
						st_q     <= S_FIN;
					end else if (rd_q == end_q) begin
						st_q <= S_DRAIN;
					end else if (mode_q == W_RIGHT) begin
						rd_q <= rd_q - ole_pkg::IDX_W'(1);
					end else begin
						rd_q <= rd_q + ole_pkg::IDX_W'(1);
					end
				end
				S_DRAIN: begin
					pend_q <= 1'b0;
					case (mode_q)
						W_RIGHT: begin
							st_q <= S_PUT;
						end
						W_LEFT: begin
							count_q <= last_cnt;
							st_q    <= S_FIN;
						end
						default: begin
							if (hit) begin
								status_q <= ole_pkg::ST_OK;
								found_q  <= pend_a_q;
							end
							st_q <= S_FIN;
						end
					endcase
				end
				S_PUT: begin
					count_q  <= count_q + ole_pkg::CNT_W'(1);
					status_q <= ole_pkg::ST_OK;
					st_q     <= S_FIN;
				end
				S_FIN: begin
					if (res_take) begin
						st_q <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### rtl/core/ordered_list_engine.sv
// ---------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed 32-bit values with deque, positional insert
// and linear search actions, one result per action.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) moves one action per transfer: action,
//   value, position and key. Output channel (out_valid/out_ready) moves one
//   result per transfer: status, found_index and count_now.
//   The engine works on one action at a time; in_ready is high only while
//   the sequencer is idle.
//   Steps, from input transfer to result in the output register:
//     pop back, rejected or unused actions : no store access
//     push back / insert at the end        : value written at the end
//     push front / insert at position p    : entries from the end down to p
//                                            move up, then value written at p
//     pop front                            : entries above 0 move down
//     search                               : scan from 0 up to the first match
//   The walk moves or compares one entry per cycle through the single read
//   port of the entry store.
//   Reset empties the list at once: no clearing pass, the store contents are
//   never read above the count.
//   A stalled receiver holds the result in the output register; the
//   sequencer then parks its own finished result and accepts no new action.
// ---------------------------------------------------------------------------
`include "ordered_list_engine_defines.svh"

module ordered_list_engine (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [ole_pkg::ACT_W-1:0]         action,
	input  logic signed [ole_pkg::DATA_W-1:0] value,
	input  logic [ole_pkg::POS_W-1:0]         position,
	input  logic signed [ole_pkg::DATA_W-1:0] key,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [ole_pkg::ST_W-1:0]          status,
	output logic [ole_pkg::FIDX_W-1:0]        found_index,
	output logic [ole_pkg::OCNT_W-1:0]        count_now
);

	ole_pkg::ole_mem_req_t      mem_req;
	logic [ole_pkg::DATA_W-1:0] rdata;
	ole_pkg::ole_res_t          res;
	logic                       res_valid;
	logic                       res_take;
	logic                       seq_idle;
	logic                       out_valid_q;
	logic [ole_pkg::ST_W-1:0]   status_q;
	logic [ole_pkg::FIDX_W-1:0] found_q;
	logic [ole_pkg::OCNT_W-1:0] count_q;

	// Accept a new action only while the sequencer sits idle
	assign in_ready = seq_idle;

	// Move the finished result into the output register when it is free or
	// being emptied in this cycle
	assign res_take = res_valid && (!out_valid_q || out_ready);

	ole_store u_store (
		.clk   (clk),
		.req   (mem_req),
		.rdata (rdata)
	);

	ole_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_valid && in_ready),
		.action    (action),
		.value     (value),
		.position  (position),
		.key       (key),
		.idle      (seq_idle),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res),
		.mem_req   (mem_req),
		.rdata     (rdata)
	);

	// Output register: hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Payload needs no reset: load only on a result transfer
	always_ff @(posedge clk) begin
		if (res_take) begin
			status_q <= res.status;
			found_q  <= ole_pkg::FIDX_W'(res.found);
			count_q  <= ole_pkg::OCNT_W'(res.count);
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign count_now   = count_q;

	`OLE_CHECK_NOW(a_count_bound, out_valid, 32'(count_now) <= ole_pkg::DEPTH, "count above depth")
	`OLE_CHECK_NOW(a_full_count, out_valid && status == ole_pkg::ST_FULL, 32'(count_now) == ole_pkg::DEPTH, "full status on a list that is not full")
	`OLE_CHECK_NOW(a_empty_count, out_valid && status == ole_pkg::ST_EMPTY, count_now == '0, "empty status on a list with entries")
	`OLE_CHECK_NEXT(a_busy_after_start, in_valid && in_ready, !in_ready, "sequencer idle after accepting an action")

endmodule

### verif/ordered_list_engine_tb.sv
// ---------------------------------------------------------------------------
// Ordered list engine testbench
// Drives list actions over the valid/ready input channel and checks each
// result against a behavioural copy of the list kept inside the bench. A
// short directed sequence covers the empty, full and last-element corners.
// It is followed by random episodes that grow, shrink or probe the list
// while both channels idle at random.
// ---------------------------------------------------------------------------
module ordered_list_engine_tb;
	import ole_pkg::*;

	// Spare action codes: the engine must ignore these and report the count
	localparam logic [ACT_W-1:0] ACT_SPARE_6 = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_7 = 3'd7;

	localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
	localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

	localparam int RANDOM_ACTIONS = 1000;
	localparam int PHASE_LEN      = 80;
	localparam int QUIET_LIMIT    = 4000;
	localparam int TAIL_CYCLES    = 2 * DEPTH + 8;
	localparam int REPORT_MAX     = 10;

	typedef struct packed {
		logic [ACT_W-1:0]         act;
		logic signed [DATA_W-1:0] val;
		logic [POS_W-1:0]         pos;
		logic signed [DATA_W-1:0] key;
	} list_op_t;

	typedef struct packed {
		logic [ST_W-1:0]   status;
		logic [FIDX_W-1:0] found;
		logic [OCNT_W-1:0] count;
	} list_res_t;

	typedef enum int {MOOD_GROW, MOOD_SHRINK, MOOD_PROBE, MOOD_MIXED} mood_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_ready;
	logic [ACT_W-1:0]         action;
	logic signed [DATA_W-1:0] value;
	logic [POS_W-1:0]         position;
	logic signed [DATA_W-1:0] key;
	logic                     out_valid;
	logic                     out_ready;
	logic [ST_W-1:0]          status;
	logic [FIDX_W-1:0]        found_index;
	logic [OCNT_W-1:0]        count_now;

	// Actions waiting to be driven, and results waiting to come back
	list_op_t  action_queue[$];
	list_res_t pending_results[$];

	// Behavioural copy of the list; index 0 is the front
	logic signed [DATA_W-1:0] list_mem [DEPTH];
	int                       list_len;

	// Length the list will have once every planned action has run; steers
	// the random episodes towards full and empty
	int gen_len;
	logic signed [DATA_W-1:0] value_pool [8];

	logic     in_taken;
	list_op_t next_op;
	int       n_launched;
	int       n_accepted;
	int       n_checked;
	int       n_planned;
	int       n_directed;
	int       errors;
	int       quiet_cycles;
	int       status_tally [5];

	ordered_list_engine dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.value      (value),
		.position   (position),
		.key        (key),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.found_index(found_index),
		.count_now  (count_now)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// List behaviour: apply one action to the local copy and return the
	// result the engine must produce for it.
	// -----------------------------------------------------------------------
	function automatic list_res_t apply_action(list_op_t op);
		list_res_t r;
		bit        adding;
		bit        hit;
		int        where;
		r        = '0;
		r.status = ST_OK;
		adding   = 1'b0;
		hit      = 1'b0;
		where    = 0;
		case (op.act)
			ACT_ADD_FRONT: begin
				adding = 1'b1;
				where  = 0;
			end
			ACT_ADD_BACK: begin
				adding = 1'b1;
				where  = list_len;
			end
			ACT_INSERT: begin
				adding = 1'b1;
				where  = op.pos;
			end
			ACT_DROP_FRONT, ACT_DROP_BACK: begin
				if (list_len == 0) begin
					r.status = ST_EMPTY;
				end else begin
					// close the gap at the front; a pop at the back just shortens
					if (op.act == ACT_DROP_FRONT)
						for (int i = 0; i < list_len - 1; i++)
							list_mem[i] = list_mem[i + 1];
					list_len--;
				end
			end
			ACT_SEARCH: begin
				// first match wins; an empty list is simply not found
				r.status = ST_NOTFOUND;
				for (int i = 0; i < list_len && !hit; i++) begin
					if (list_mem[i] == op.key) begin
						hit      = 1'b1;
						r.status = ST_OK;
						r.found  = i[FIDX_W-1:0];
					end
				end
			end
			default: ;
		endcase
		if (adding) begin
			// position above the count is rejected before the full check
			if (where > list_len) begin
				r.status = ST_BADPOS;
			end else if (list_len >= DEPTH) begin
				r.status = ST_FULL;
			end else begin
				for (int i = list_len; i > where; i--)
					list_mem[i] = list_mem[i - 1];
				list_mem[where] = op.val;
				list_len++;
			end
		end
		r.count = list_len[OCNT_W-1:0];
		return r;
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus planning
	// -----------------------------------------------------------------------
	task automatic plan(input logic [ACT_W-1:0] act, input logic signed [DATA_W-1:0] val,
			input logic [POS_W-1:0] pos, input logic signed [DATA_W-1:0] k);
		list_op_t op;
		op.act = act;
		op.val = val;
		op.pos = pos;
		op.key = k;
		action_queue = {action_queue, op};
		n_planned++;
		case (act)
			ACT_ADD_FRONT, ACT_ADD_BACK: if (gen_len < DEPTH) gen_len++;
			ACT_INSERT: if (pos <= gen_len && gen_len < DEPTH) gen_len++;
			ACT_DROP_FRONT, ACT_DROP_BACK: if (gen_len > 0) gen_len--;
			default: ;
		endcase
	endtask

	function automatic logic [ACT_W-1:0] pick_action(mood_t mood);
		int add_pct;
		int pop_pct;
		int roll;
		int pick;
		roll = $urandom_range(99, 0);
		pick = $urandom_range(2, 0);
		case (mood)
			MOOD_GROW: begin
				add_pct = 70;
				pop_pct = 15;
			end
			MOOD_SHRINK: begin
				add_pct = 15;
				pop_pct = 70;
			end
			MOOD_PROBE: begin
				add_pct = 20;
				pop_pct = 20;
			end
			default: begin
				add_pct = 40;
				pop_pct = 30;
			end
		endcase
		if ($urandom_range(99, 0) < 3)
			return pick[0] ? ACT_SPARE_6 : ACT_SPARE_7;
		if (roll < add_pct)
			return (pick == 0) ? ACT_ADD_FRONT : (pick == 1) ? ACT_ADD_BACK : ACT_INSERT;
		if (roll < add_pct + pop_pct)
			return pick[0] ? ACT_DROP_FRONT : ACT_DROP_BACK;
		return ACT_SEARCH;
	endfunction

	// Values come often from a small pool so that searches find something
	function automatic logic signed [DATA_W-1:0] pick_word(int pool_pct);
		if ($urandom_range(99, 0) < pool_pct)
			return value_pool[$urandom_range(7, 0)];
		return $urandom;
	endfunction

	task automatic plan_directed();
		// empty-list corners: pops, search and an insert past the end
		plan(ACT_DROP_FRONT, $urandom, 5'd0, $urandom);
		plan(ACT_DROP_BACK, $urandom, 5'd0, $urandom);
		plan(ACT_SEARCH, $urandom, 5'd0, 32'sd0);
		plan(ACT_INSERT, WORD_MAX, 5'd1, $urandom);
		plan(ACT_INSERT, WORD_MAX, 5'd0, $urandom);
		plan(ACT_SEARCH, $urandom, 5'd0, WORD_MAX);
		// popping the only element leaves the list empty
		plan(ACT_DROP_BACK, $urandom, 5'd0, $urandom);
		plan(ACT_SPARE_6, $urandom, 5'($urandom_range(16, 0)), $urandom);
		plan(ACT_SPARE_7, $urandom, 5'($urandom_range(16, 0)), $urandom);
		// fill to the brim through every way of adding
		for (int i = 0; i < DEPTH; i++) begin
			case (i % 4)
				0: plan(ACT_ADD_BACK, (i == 0) ? WORD_MIN : $urandom, 5'd0, $urandom);
				1: plan(ACT_ADD_FRONT, (i == 1) ? -32'sd1 : $urandom, 5'd0, $urandom);
				2: plan(ACT_INSERT, (i == 2) ? 32'sd0 : $urandom, 5'(gen_len), $urandom);
				default: plan(ACT_INSERT, (i == 3) ? WORD_MAX : $urandom, 5'(gen_len / 2),
						$urandom);
			endcase
		end
		// full list: every add is refused, and an out-of-range position reports a bad position ahead of full
		plan(ACT_ADD_FRONT, $urandom, 5'd0, $urandom);
		plan(ACT_ADD_BACK, $urandom, 5'd0, $urandom);
		plan(ACT_INSERT, $urandom, 5'd16, $urandom);
		plan(ACT_INSERT, $urandom, 5'd31, $urandom);
		plan(ACT_SEARCH, $urandom, 5'd0, WORD_MIN);
		plan(ACT_SEARCH, $urandom, 5'd0, $urandom);
	endtask

	task automatic plan_random(input int n_items);
		mood_t            mood;
		int               run_left;
		int               made;
		logic [ACT_W-1:0] act;
		logic [POS_W-1:0] pos;
		mood     = MOOD_MIXED;
		run_left = 0;
		made     = 0;
		while (made < n_items) begin
			if (run_left == 0) begin
				mood     = mood_t'($urandom_range(3, 0));
				run_left = $urandom_range(24, 4);
			end
			run_left--;
			act = pick_action(mood);
			// mostly a legal position, sometimes anywhere in range
			if ($urandom_range(99, 0) < 80)
				pos = 5'($urandom_range(gen_len, 0));
			else
				pos = 5'($urandom_range(16, 0));
			plan(act, pick_word(40), pos, pick_word(60));
			if (act != ACT_SPARE_6 && act != ACT_SPARE_7)
				made++;
		end
	endtask

	// -----------------------------------------------------------------------
	// Idling: phases of no idling, sender gaps, receiver stalls, and both
	// -----------------------------------------------------------------------
	function automatic bit chance(int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic int send_idle_pct();
		case ((n_launched / PHASE_LEN) % 4)
			1: return 68;
			3: return 35;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct();
		case ((n_launched / PHASE_LEN) % 4)
			2: return 68;
			3: return 35;
			default: return 0;
		endcase
	endfunction

	// -----------------------------------------------------------------------
	// Driver: change inputs on the falling edge. Hold an action until its
	// transfer has been seen at a rising edge, then advance or go idle.
	// -----------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (action_queue.size() != 0 && !chance(send_idle_pct())) begin
					next_op = action_queue[0];
					action_queue.delete(0);
					action   <= next_op.act;
					value    <= next_op.val;
					position <= next_op.pos;
					key      <= next_op.key;
					in_valid <= 1'b1;
					n_launched++;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= !chance(recv_stall_pct());
		end
	end

	// -----------------------------------------------------------------------
	// Monitor: sample both channels on the rising edge. Predict on every
	// input transfer, check on every output transfer, and watch for a hang.
	// -----------------------------------------------------------------------
	always @(posedge clk) begin
		list_op_t  seen;
		list_res_t want;
		if (!arst_n) begin
			in_taken <= 1'b0;
		end else begin
			in_taken <= in_valid && in_ready;

			if (in_valid && in_ready) begin
				seen.act = action;
				seen.val = value;
				seen.pos = position;
				seen.key = key;
				want = apply_action(seen);
				pending_results = {pending_results, want};
				status_tally[want.status]++;
				n_accepted++;
			end

			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: result with nothing outstanding: status %0d index %0d count %0d",
								$time, status, found_index, count_now);
				end else begin
					want = pending_results[0];
					pending_results.delete(0);
					n_checked++;
					if (status !== want.status || found_index !== want.found
							|| count_now !== want.count) begin
						errors++;
						if (errors <= REPORT_MAX)
							$display("%0t: result %0d mismatch: status %0d/%0d index %0d/%0d count %0d/%0d (exp/got)",
									$time, n_checked, want.status, status, want.found,
									found_index, want.count, count_now);
					end
				end
			end

			// drop out if neither channel moves for far longer than the slowest walk
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d of %0d actions taken",
						$time, QUIET_LIMIT, n_accepted, n_planned);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	// -----------------------------------------------------------------------
	// Sequence: plan the stimulus, reset once, wait for everything to drain
	// -----------------------------------------------------------------------
	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		out_ready = 1'b0;
		action    = '0;
		value     = '0;
		position  = '0;
		key       = '0;
		list_len  = 0;
		gen_len   = 0;
		n_launched   = 0;
		n_accepted   = 0;
		n_checked    = 0;
		n_planned    = 0;
		errors       = 0;
		quiet_cycles = 0;
		foreach (status_tally[i])
			status_tally[i] = 0;
		value_pool[0] = WORD_MIN;
		value_pool[1] = WORD_MAX;
		value_pool[2] = 32'sd0;
		value_pool[3] = -32'sd1;
		value_pool[4] = 32'sd1;
		for (int i = 5; i < 8; i++)
			value_pool[i] = $urandom;

		plan_directed();
		n_directed = n_planned;
		plan_random(RANDOM_ACTIONS);

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (n_accepted < n_planned)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		// leave room for any stray result to show up
		repeat (TAIL_CYCLES) @(posedge clk);
		errors += pending_results.size();

		$display("%0d actions transferred (%0d directed), %0d results checked",
				n_accepted, n_directed, n_checked);
		$display("outcomes: ok %0d, empty %0d, bad position %0d, full %0d, not found %0d",
				status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_BADPOS],
				status_tally[ST_FULL], status_tally[ST_NOTFOUND]);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
